[rtl/cone_mesh_vertex_generator_assert.svh]
// ----------------------------------------------------------------------------
// Cone mesh vertex generator assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CONE_MESH_VERTEX_GENERATOR_ASSERT_SVH
`define CONE_MESH_VERTEX_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CMVG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmvg assertion failed");

// next-cycle implication
`define CMVG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmvg assertion failed");

`else

`define CMVG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CMVG_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/cmvg_pkg.sv]
// ----------------------------------------------------------------------------
// Cone mesh vertex generator package
// Field widths, register map, phase codes, microcode table and sine entries.
// ----------------------------------------------------------------------------
package cmvg_pkg;

   // field widths
   localparam int RADIUS_W   = 15;
   localparam int Y_W        = 15;
   localparam int ANGLE_W    = 16;
   localparam int CNT_REG_W  = 10;
   localparam int SIN_W      = 16;
   localparam int SIN_FRAC_W = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
   localparam logic [Y_W-1:0]     Y_MAX        = 15'h7FFF;

   // register map
   typedef logic [CSR_ADDR_W-1:0] csr_index_type;
   localparam csr_index_type CSR_BASE_RADIUS      = 3'd0;
   localparam csr_index_type CSR_CONE_HEIGHT      = 3'd1;
   localparam csr_index_type CSR_SLICE_COUNT      = 3'd2;
   localparam csr_index_type CSR_STACK_COUNT      = 3'd3;
   localparam csr_index_type CSR_ANGLE_STEP       = 3'd4;
   localparam csr_index_type CSR_RING_RADIUS_STEP = 3'd5;
   localparam csr_index_type CSR_RING_HEIGHT_STEP = 3'd6;

   localparam logic [RADIUS_W-1:0]  RST_BASE_RADIUS      = 15'd256;
   localparam logic [Y_W-1:0]       RST_CONE_HEIGHT      = 15'd256;
   localparam logic [CNT_REG_W-1:0] RST_SLICE_COUNT      = 10'd8;
   localparam logic [CNT_REG_W-1:0] RST_STACK_COUNT      = 10'd4;
   localparam logic [ANGLE_W-1:0]   RST_ANGLE_STEP       = 16'd8192;
   localparam logic [RADIUS_W-1:0]  RST_RING_RADIUS_STEP = 15'd64;
   localparam logic [Y_W-1:0]       RST_RING_HEIGHT_STEP = 15'd64;

   // traversal phase
   typedef logic [1:0] phase_type;
   localparam phase_type PH_BASE = 2'd0;
   localparam phase_type PH_SIDE = 2'd1;
   localparam phase_type PH_APEX = 2'd2;
   localparam phase_type PH_BAD  = 2'd3;

   // microcode fields
   typedef logic [2:0] step_type;
   typedef logic [1:0] asel_type;
   typedef logic [1:0] bsel_type;
   typedef logic [2:0] dst_type;
   typedef logic [1:0] jmp_type;

   localparam asel_type ASEL_SLICE  = 2'd0;
   localparam asel_type ASEL_LEVEL  = 2'd1;
   localparam asel_type ASEL_RADIUS = 2'd2;

   localparam bsel_type BSEL_ASTEP = 2'd0;
   localparam bsel_type BSEL_RRS   = 2'd1;
   localparam bsel_type BSEL_RHS   = 2'd2;
   localparam bsel_type BSEL_ROM   = 2'd3;

   localparam dst_type DST_NONE   = 3'd0;
   localparam dst_type DST_ANGLE  = 3'd1;
   localparam dst_type DST_RADIUS = 3'd2;
   localparam dst_type DST_HEIGHT = 3'd3;
   localparam dst_type DST_X      = 3'd4;
   localparam dst_type DST_Z      = 3'd5;

   localparam jmp_type JMP_NEXT       = 2'd0;
   localparam jmp_type JMP_ALWAYS     = 2'd1;
   localparam jmp_type JMP_IF_NOPOINT = 2'd2;

   localparam step_type STEP_IDLE       = 3'd0;
   localparam step_type STEP_ANGLE_MUL  = 3'd1;
   localparam step_type STEP_DEC_MUL    = 3'd2;
   localparam step_type STEP_HGT_MUL    = 3'd3;
   localparam step_type STEP_SIN_MUL    = 3'd4;
   localparam step_type STEP_COS_MUL    = 3'd5;
   localparam step_type STEP_Z_WB       = 3'd6;
   localparam step_type STEP_OUT        = 3'd7;

   typedef struct packed {
      asel_type a_sel;
      bsel_type b_sel;
      dst_type  dst;
      logic     rom_rd;
      logic     rom_cos;
      logic     wait_req;
      logic     wait_out;
      jmp_type  jmp;
      step_type target;
   } ucode_type;

   // Control store. The product register sits between multiply and writeback,
   // so each step writes back what the step before it multiplied.
   function automatic ucode_type ucode(input step_type step);
      ucode_type uc;
      uc = '{a_sel: ASEL_SLICE, b_sel: BSEL_ASTEP, dst: DST_NONE, rom_rd: 1'b0,
             rom_cos: 1'b0, wait_req: 1'b0, wait_out: 1'b0, jmp: JMP_NEXT,
             target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            uc.wait_req = 1'b1;
            uc.jmp      = JMP_IF_NOPOINT;
            uc.target   = STEP_OUT;
         end
         STEP_ANGLE_MUL: begin
            uc.a_sel = ASEL_SLICE;
            uc.b_sel = BSEL_ASTEP;
         end
         STEP_DEC_MUL: begin
            uc.a_sel = ASEL_LEVEL;
            uc.b_sel = BSEL_RRS;
            uc.dst   = DST_ANGLE;
         end
         STEP_HGT_MUL: begin
            uc.a_sel  = ASEL_LEVEL;
            uc.b_sel  = BSEL_RHS;
            uc.dst    = DST_RADIUS;
            uc.rom_rd = 1'b1;
         end
         STEP_SIN_MUL: begin
            uc.a_sel   = ASEL_RADIUS;
            uc.b_sel   = BSEL_ROM;
            uc.dst     = DST_HEIGHT;
            uc.rom_rd  = 1'b1;
            uc.rom_cos = 1'b1;
         end
         STEP_COS_MUL: begin
            uc.a_sel = ASEL_RADIUS;
            uc.b_sel = BSEL_ROM;
            uc.dst   = DST_X;
         end
         STEP_Z_WB: begin
            uc.dst = DST_Z;
         end
         STEP_OUT: begin
            uc.wait_out = 1'b1;
            uc.jmp      = JMP_ALWAYS;
            uc.target   = STEP_IDLE;
         end
         default: begin
            uc.jmp    = JMP_ALWAYS;
            uc.target = STEP_IDLE;
         end
      endcase
      return uc;
   endfunction

   // sine table generation, unsigned Q2.30 Taylor series to degree 11
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // phase_q32: table position as a fraction of a turn over 2^32
   function automatic logic [SIN_W-1:0] sine_entry(input logic [63:0] phase_q32);
      logic [1:0]  quad;
      logic [63:0] f;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      quad = phase_q32[31:30];
      f    = {34'd0, phase_q32[29:0]};
      if (quad[0]) begin
         f = Q30_ONE - f;
      end
      x  = (f * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s + 64'd16384) >> 15;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      if (quad[1]) begin
         v = (64'h10000 - v) & 64'hFFFF;
      end
      return v[SIN_W-1:0];
   endfunction

endpackage

[rtl/cmvg_sine_rom.sv]
// ----------------------------------------------------------------------------
// Cone mesh vertex generator sine table
// Full-turn Q1.15 sine ROM addressed by a 16-bit angle, registered read.
// ----------------------------------------------------------------------------
module cmvg_sine_rom #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic        [cmvg_pkg::ANGLE_W-1:0] rd_angle,
   output logic signed [cmvg_pkg::SIN_W-1:0]   rd_data
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int PROD_W = cmvg_pkg::ANGLE_W + IDX_W + 1;

   logic [cmvg_pkg::SIN_W-1:0] rom [DEPTH];
   logic [PROD_W-1:0]          idx_prod;
   logic [IDX_W-1:0]           rd_idx;
   logic [cmvg_pkg::SIN_W-1:0] rd_data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      localparam logic [63:0] PHASE_Q32 = (64'(k) << 32) / DEPTH;
      assign rom[k] = cmvg_pkg::sine_entry(PHASE_Q32);
   end

   // entry = angle * DEPTH / 65536, always below DEPTH
   assign idx_prod = PROD_W'(rd_angle) * PROD_W'(DEPTH);
   assign rd_idx   = idx_prod[cmvg_pkg::ANGLE_W +: IDX_W];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom[rd_idx];
      end
   end

   assign rd_data = $signed(rd_data_ff);

endmodule

[rtl/cone_mesh_vertex_generator.sv]
// ----------------------------------------------------------------------------
// Cone mesh vertex generator
// Walks a cone triangle list one vertex per request transaction.
// ----------------------------------------------------------------------------
// Usage: every request transaction yields exactly one response transaction.
// req_restart = 1 starts a new mesh and returns its first vertex; 0 returns
// the next vertex. After the final vertex (rsp_last_vertex) or while idle,
// responses carry zero coordinates with rsp_mesh_done set.
// Configuration is written through csr_wr_en / csr_index / csr_wdata while no
// transaction is in flight; register values are used live.
// Sequencing: a rim or ring vertex runs through an 8-step microprogram on one
// shared multiplier and the sine ROM port (angle, radius decrement, height,
// r*sin, r*cos); the next request is taken only after its response has been
// loaded into the output register. Origin, apex and done responses skip the
// multiply steps and go from acceptance straight to the output step.
// Reset (synchronous, active high) loads the default registers and leaves the
// block idle in the finished state until a restart. If the receiver stalls,
// the response holds in the output register; one more request may be taken
// meanwhile, and its output step waits until the held response is delivered.
// ----------------------------------------------------------------------------
`include "cone_mesh_vertex_generator_assert.svh"

module cone_mesh_vertex_generator #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int COORD_WIDTH      = 16,
   parameter int COUNT_WIDTH      = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic        [cmvg_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic        [cmvg_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [COORD_WIDTH-1:0]          rsp_vert_x,
   output logic        [cmvg_pkg::Y_W-1:0]        rsp_vert_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_vert_z,
   output logic                                   rsp_last_vertex,
   output logic                                   rsp_mesh_done
);

   localparam int CMP_W  = (COUNT_WIDTH + 1 > cmvg_pkg::CNT_REG_W) ?
                           COUNT_WIDTH + 1 : cmvg_pkg::CNT_REG_W;
   localparam int OPA_W  = ((CMP_W > cmvg_pkg::RADIUS_W) ? CMP_W : cmvg_pkg::RADIUS_W) + 1;
   localparam int OPB_W  = cmvg_pkg::ANGLE_W + 1;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam logic signed [PROD_W-1:0] CRD_MAX =
      PROD_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [PROD_W-1:0] CRD_MIN    = ~CRD_MAX;
   localparam logic signed [PROD_W-1:0] ROUND_HALF =
      PROD_W'(64'sd1 <<< (cmvg_pkg::SIN_FRAC_W - 1));

   // configuration
   logic [cmvg_pkg::RADIUS_W-1:0]  base_radius_ff;
   logic [cmvg_pkg::Y_W-1:0]       cone_height_ff;
   logic [cmvg_pkg::CNT_REG_W-1:0] slice_count_ff;
   logic [cmvg_pkg::CNT_REG_W-1:0] stack_count_ff;
   logic [cmvg_pkg::ANGLE_W-1:0]   angle_step_ff;
   logic [cmvg_pkg::RADIUS_W-1:0]  ring_radius_step_ff;
   logic [cmvg_pkg::Y_W-1:0]       ring_height_step_ff;

   // traversal state
   cmvg_pkg::phase_type    phase_ff,  phase_in;
   logic [COUNT_WIDTH-1:0] slice_ff,  slice_in;
   logic [COUNT_WIDTH-1:0] level_ff,  level_in;
   logic [2:0]             corner_ff, corner_in;
   logic                   finished_ff, finished_in;

   cmvg_pkg::phase_type            phase_base;
   logic [COUNT_WIDTH-1:0]         slice_base;
   logic [COUNT_WIDTH-1:0]         level_base;
   logic [2:0]                     corner_base;
   logic                           fin_base;
   logic [CMP_W-1:0]               slice_inc;
   logic [CMP_W-1:0]               level_inc;
   logic [3:0]                     corner_inc;
   logic                           slice_wrap;
   logic [cmvg_pkg::CNT_REG_W-1:0] top_lvl;
   cmvg_pkg::phase_type            ring_phase;

   // job decoded at acceptance
   logic                   pt;
   logic                   pt_next;
   logic [CMP_W-1:0]       pt_level;
   logic [CMP_W-1:0]       pt_aslice;
   logic                   pt_zero_ang;
   logic [cmvg_pkg::Y_W-1:0] pt_y;
   logic                   pt_last;
   logic                   pt_done;

   logic                     job_point_ff;
   logic [CMP_W-1:0]         job_aslice_ff;
   logic                     job_zero_ang_ff;
   logic [CMP_W-1:0]         job_level_ff;
   logic [cmvg_pkg::Y_W-1:0] job_y_ff;
   logic                     job_last_ff;
   logic                     job_done_ff;

   // sequencer
   cmvg_pkg::step_type  step_ff, step_in;
   cmvg_pkg::ucode_type uc;
   logic                req_accept;
   logic                out_stall;
   logic                out_load;
   logic                seq_hold;

   // datapath
   logic signed [OPA_W-1:0]               mul_a;
   logic signed [OPB_W-1:0]               mul_b;
   logic signed [PROD_W-1:0]              prod_ff;
   logic        [PROD_W-1:0]              prod_mag;
   logic        [cmvg_pkg::ANGLE_W-1:0]   angle_ff;
   logic        [cmvg_pkg::ANGLE_W-1:0]   rom_angle;
   logic signed [cmvg_pkg::SIN_W-1:0]     rom_q;
   logic        [cmvg_pkg::RADIUS_W-1:0]  radius_ff;
   logic        [cmvg_pkg::RADIUS_W-1:0]  radius_next;
   logic        [cmvg_pkg::Y_W-1:0]       height_ff;
   logic        [cmvg_pkg::Y_W-1:0]       height_next;
   logic signed [PROD_W-1:0]              crd_round;
   logic signed [PROD_W-1:0]              crd_shift;
   logic signed [PROD_W-1:0]              crd_sat;
   logic signed [COORD_WIDTH-1:0]         crd_x_ff;
   logic signed [COORD_WIDTH-1:0]         crd_z_ff;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_WIDTH-1:0]  rsp_vert_x_ff;
   logic [cmvg_pkg::Y_W-1:0]       rsp_vert_y_ff;
   logic signed [COORD_WIDTH-1:0]  rsp_vert_z_ff;
   logic                           rsp_last_vertex_ff;
   logic                           rsp_mesh_done_ff;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         base_radius_ff      <= cmvg_pkg::RST_BASE_RADIUS;
         cone_height_ff      <= cmvg_pkg::RST_CONE_HEIGHT;
         slice_count_ff      <= cmvg_pkg::RST_SLICE_COUNT;
         stack_count_ff      <= cmvg_pkg::RST_STACK_COUNT;
         angle_step_ff       <= cmvg_pkg::RST_ANGLE_STEP;
         ring_radius_step_ff <= cmvg_pkg::RST_RING_RADIUS_STEP;
         ring_height_step_ff <= cmvg_pkg::RST_RING_HEIGHT_STEP;
      end else if (csr_wr_en) begin
         case (csr_index)
            cmvg_pkg::CSR_BASE_RADIUS:
               base_radius_ff <= csr_wdata[cmvg_pkg::RADIUS_W-1:0];
            cmvg_pkg::CSR_CONE_HEIGHT:
               cone_height_ff <= csr_wdata[cmvg_pkg::Y_W-1:0];
            cmvg_pkg::CSR_SLICE_COUNT:
               slice_count_ff <= csr_wdata[cmvg_pkg::CNT_REG_W-1:0];
            cmvg_pkg::CSR_STACK_COUNT:
               stack_count_ff <= csr_wdata[cmvg_pkg::CNT_REG_W-1:0];
            cmvg_pkg::CSR_ANGLE_STEP:
               angle_step_ff <= csr_wdata[cmvg_pkg::ANGLE_W-1:0];
            cmvg_pkg::CSR_RING_RADIUS_STEP:
               ring_radius_step_ff <= csr_wdata[cmvg_pkg::RADIUS_W-1:0];
            cmvg_pkg::CSR_RING_HEIGHT_STEP:
               ring_height_step_ff <= csr_wdata[cmvg_pkg::Y_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // mesh traversal: decode the vertex for this transaction, advance counters
   // ------------------------------------------------------------------------
   always_comb begin
      slice_base  = req_restart ? '0 : slice_ff;
      level_base  = req_restart ? '0 : level_ff;
      corner_base = req_restart ? '0 : corner_ff;
      phase_base  = req_restart ? cmvg_pkg::PH_BASE : phase_ff;
      fin_base    = req_restart ? (slice_count_ff == '0) : finished_ff;

      slice_inc  = CMP_W'(slice_base) + CMP_W'(1);
      level_inc  = CMP_W'(level_base) + CMP_W'(1);
      corner_inc = {1'b0, corner_base} + 4'd1;
      slice_wrap = slice_inc >= CMP_W'(slice_count_ff);
      top_lvl    = (stack_count_ff == '0) ? '0 : stack_count_ff - 1'b1;
      ring_phase = (top_lvl != '0) ? cmvg_pkg::PH_SIDE : cmvg_pkg::PH_APEX;

      phase_in    = phase_base;
      slice_in    = slice_base;
      level_in    = level_base;
      corner_in   = corner_base;
      finished_in = fin_base;

      pt       = 1'b0;
      pt_next  = 1'b0;
      pt_level = '0;
      pt_y     = '0;
      pt_last  = 1'b0;
      pt_done  = 1'b0;

      if (fin_base) begin
         pt_done = 1'b1;
      end else begin
         case (phase_base)
            cmvg_pkg::PH_BASE: begin
               // rim, origin, next rim
               if (corner_base == 3'd0) begin
                  pt = 1'b1;
               end else if (corner_base == 3'd2) begin
                  pt      = 1'b1;
                  pt_next = 1'b1;
               end
               if (corner_inc >= 4'd3) begin
                  corner_in = '0;
                  level_in  = '0;
                  slice_in  = slice_inc[COUNT_WIDTH-1:0];
                  if (slice_wrap) begin
                     slice_in = '0;
                     phase_in = ring_phase;
                  end
               end else begin
                  corner_in = corner_inc[2:0];
               end
            end
            cmvg_pkg::PH_SIDE: begin
               pt       = 1'b1;
               pt_next  = corner_base inside {3'd1, 3'd4, 3'd5};
               pt_level = (corner_base inside {3'd2, 3'd3, 3'd5}) ?
                          level_inc : CMP_W'(level_base);
               if (corner_inc >= 4'd6) begin
                  corner_in = '0;
                  level_in  = level_inc[COUNT_WIDTH-1:0];
                  if (level_inc >= CMP_W'(top_lvl)) begin
                     level_in = '0;
                     phase_in = cmvg_pkg::PH_APEX;
                  end
               end else begin
                  corner_in = corner_inc[2:0];
               end
            end
            cmvg_pkg::PH_APEX: begin
               if (corner_base < 3'd2) begin
                  pt       = 1'b1;
                  pt_next  = (corner_base == 3'd1);
                  pt_level = CMP_W'(top_lvl);
               end else begin
                  pt_y    = cone_height_ff;
                  pt_last = slice_wrap;
               end
               if (corner_inc >= 4'd3) begin
                  corner_in = '0;
                  level_in  = '0;
                  slice_in  = slice_inc[COUNT_WIDTH-1:0];
                  if (slice_wrap) begin
                     finished_in = 1'b1;
                  end else begin
                     phase_in = ring_phase;
                  end
               end else begin
                  corner_in = corner_inc[2:0];
               end
            end
            default: begin
               // unused phase code behaves as finished
               pt_done = 1'b1;
            end
         endcase
      end

      pt_aslice   = pt_next ? slice_inc : CMP_W'(slice_base);
      pt_zero_ang = pt_next && slice_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cmvg_pkg::PH_BASE;
         slice_ff    <= '0;
         level_ff    <= '0;
         corner_ff   <= '0;
         finished_ff <= 1'b1;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         slice_ff    <= slice_in;
         level_ff    <= level_in;
         corner_ff   <= corner_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         job_point_ff    <= pt;
         job_aslice_ff   <= pt_aslice;
         job_zero_ang_ff <= pt_zero_ang;
         job_level_ff    <= pt_level;
         job_y_ff        <= pt_y;
         job_last_ff     <= pt_last;
         job_done_ff     <= pt_done;
      end
   end

   // ------------------------------------------------------------------------
   // microcode sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      uc         = cmvg_pkg::ucode(step_ff);
      req_accept = req_valid && uc.wait_req;
      out_stall  = uc.wait_out && rsp_valid_ff && !rsp_ready;
      out_load   = uc.wait_out && !out_stall;
      seq_hold   = (uc.wait_req && !req_valid) || out_stall;

      step_in = step_ff;
      if (!seq_hold) begin
         case (uc.jmp)
            cmvg_pkg::JMP_NEXT:       step_in = step_ff + 3'd1;
            cmvg_pkg::JMP_ALWAYS:     step_in = uc.target;
            cmvg_pkg::JMP_IF_NOPOINT: step_in = pt ? step_ff + 3'd1 : uc.target;
            default:                  step_in = cmvg_pkg::STEP_IDLE;
         endcase
      end
   end

   assign req_ready = uc.wait_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= cmvg_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // ------------------------------------------------------------------------
   // datapath: one multiplier, product register, writeback
   // ------------------------------------------------------------------------
   always_comb begin
      case (uc.a_sel)
         cmvg_pkg::ASEL_LEVEL:  mul_a = $signed(OPA_W'(job_level_ff));
         cmvg_pkg::ASEL_RADIUS: mul_a = $signed(OPA_W'(radius_ff));
         default:               mul_a = $signed(OPA_W'(job_aslice_ff));
      endcase
      case (uc.b_sel)
         cmvg_pkg::BSEL_RRS: mul_b = $signed(OPB_W'(ring_radius_step_ff));
         cmvg_pkg::BSEL_RHS: mul_b = $signed(OPB_W'(ring_height_step_ff));
         cmvg_pkg::BSEL_ROM: mul_b = OPB_W'(rom_q);
         default:            mul_b = $signed(OPB_W'(angle_step_ff));
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign rom_angle = uc.rom_cos ? angle_ff + cmvg_pkg::QUARTER_TURN : angle_ff;

   cmvg_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock    (clock),
      .rd_en    (uc.rom_rd),
      .rd_angle (rom_angle),
      .rd_data  (rom_q)
   );

   // radius clamp, height saturation, coordinate round and saturate
   always_comb begin
      prod_mag    = $unsigned(prod_ff);
      radius_next = (prod_mag >= PROD_W'(base_radius_ff)) ?
                    '0 : base_radius_ff - prod_ff[cmvg_pkg::RADIUS_W-1:0];
      height_next = (prod_mag > PROD_W'(cmvg_pkg::Y_MAX)) ?
                    cmvg_pkg::Y_MAX : prod_ff[cmvg_pkg::Y_W-1:0];
      crd_round   = prod_ff + ROUND_HALF;
      crd_shift   = crd_round >>> cmvg_pkg::SIN_FRAC_W;
      if (crd_shift > CRD_MAX) begin
         crd_sat = CRD_MAX;
      end else if (crd_shift < CRD_MIN) begin
         crd_sat = CRD_MIN;
      end else begin
         crd_sat = crd_shift;
      end
   end

   always_ff @(posedge clock) begin
      case (uc.dst)
         cmvg_pkg::DST_ANGLE:
            angle_ff <= job_zero_ang_ff ? '0 : prod_ff[cmvg_pkg::ANGLE_W-1:0];
         cmvg_pkg::DST_RADIUS: radius_ff <= radius_next;
         cmvg_pkg::DST_HEIGHT: height_ff <= height_next;
         cmvg_pkg::DST_X:      crd_x_ff  <= crd_sat[COORD_WIDTH-1:0];
         cmvg_pkg::DST_Z:      crd_z_ff  <= crd_sat[COORD_WIDTH-1:0];
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------------
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (job_point_ff) begin
            rsp_vert_x_ff <= crd_x_ff;
            rsp_vert_y_ff <= height_ff;
            rsp_vert_z_ff <= crd_z_ff;
         end else begin
            rsp_vert_x_ff <= '0;
            rsp_vert_y_ff <= job_y_ff;
            rsp_vert_z_ff <= '0;
         end
         rsp_last_vertex_ff <= job_last_ff;
         rsp_mesh_done_ff   <= job_done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vert_x      = rsp_vert_x_ff;
   assign rsp_vert_y      = rsp_vert_y_ff;
   assign rsp_vert_z      = rsp_vert_z_ff;
   assign rsp_last_vertex = rsp_last_vertex_ff;
   assign rsp_mesh_done   = rsp_mesh_done_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `CMVG_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, step_ff != cmvg_pkg::STEP_IDLE)
   `CMVG_ASSERT_IMP(a_last_not_done, clock, reset, rsp_valid_ff, !(rsp_last_vertex_ff && rsp_mesh_done_ff))
   `CMVG_ASSERT_IMP(a_finish_on_accept, clock, reset, $rose(finished_ff), $past(req_valid && req_ready))

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cone mesh vertex generator testbench
// Streams restart/advance requests through the vertex walker under random
// sender bursts and receiver stalls, predicts every vertex with an in-bench
// fixed-point cone walker and checks each response field by field. Register
// settings change between phases while the block is idle, sometimes mid-mesh.
// ----------------------------------------------------------------------------
module tb;

   localparam int TABLE_DEPTH    = 1024;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TARGET    = 1900;

   localparam logic [63:0] UNIT_Q30    = 64'd1073741824;
   localparam logic [63:0] HALF_PI_FIX = 64'd1686629713;

   typedef struct packed {
      logic signed [15:0] x;
      logic [14:0]        y;
      logic signed [15:0] z;
      logic               last;
      logic               done;
   } vertex_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [cmvg_pkg::CSR_ADDR_W-1:0] csr_index   = '0;
   logic [cmvg_pkg::CSR_DATA_W-1:0] csr_wdata   = '0;
   logic                            req_valid   = 1'b0;
   logic                            req_restart = 1'b0;
   logic                            rsp_ready   = 1'b0;
   logic                            req_ready;
   logic                            rsp_valid;
   logic signed [15:0]              rsp_vert_x;
   logic [cmvg_pkg::Y_W-1:0]        rsp_vert_y;
   logic signed [15:0]              rsp_vert_z;
   logic                            rsp_last_vertex;
   logic                            rsp_mesh_done;

   cone_mesh_vertex_generator DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_vert_z      (rsp_vert_z),
      .rsp_last_vertex (rsp_last_vertex),
      .rsp_mesh_done   (rsp_mesh_done)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [15:0] sine_tbl [TABLE_DEPTH];
   logic [14:0] cfg_base_radius, cfg_cone_height, cfg_ring_radius_step, cfg_ring_height_step;
   logic [9:0]  cfg_slice_count, cfg_stack_count;
   logic [15:0] cfg_angle_step;
   cmvg_pkg::phase_type walk_phase;
   int unsigned slice_idx, level_idx, corner_idx;
   logic        mesh_finished;

   bit         pending_restart_q [$];
   vertex_type vertex_expect_q [$];

   bit req_taken = 1'b0;
   int error_count     = 0;
   int vertices_seen   = 0;
   int meshes_closed   = 0;
   int setups_loaded   = 0;
   int items_queued    = 0;
   int idle_cycles     = 0;

   // driver / receiver pacing
   int          burst_left = 0;
   int          gap_left   = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [7:0]  stall_cycle   = '0;

   function automatic logic signed [15:0] sine_at(input int unsigned ang);
      return sine_tbl[((ang & 32'hFFFF) * TABLE_DEPTH) >> 16];
   endfunction

   // r * s rounded half up by 15 bits, saturated to 16-bit signed
   function automatic logic signed [15:0] scale_coord(input logic [14:0] r,
                                                      input logic signed [15:0] s);
      longint p;
      longint v;
      p = longint'(r) * longint'(s) + 64'sd16384;
      v = p >>> 15;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic vertex_type ring_vertex(input int unsigned slice, input logic nxt,
                                              input int unsigned level);
      vertex_type  v;
      int unsigned dec, h, ang;
      logic [14:0] r;
      v   = '0;
      dec = level * cfg_ring_radius_step;
      h   = level * cfg_ring_height_step;
      if (nxt) ang = (slice + 1 >= cfg_slice_count) ? 0 : ((slice + 1) * cfg_angle_step) & 32'hFFFF;
      else     ang = (slice * cfg_angle_step) & 32'hFFFF;
      r   = (dec >= cfg_base_radius) ? 15'd0 : 15'(cfg_base_radius - dec);
      v.y = (h > 32767) ? 15'h7FFF : h[14:0];
      v.x = scale_coord(r, sine_at(ang));
      v.z = scale_coord(r, sine_at(ang + 16384));
      return v;
   endfunction

   // advance the mesh walk by one request and return the vertex it yields
   function automatic vertex_type next_vertex(input logic restart);
      vertex_type  v;
      int unsigned top, c, i, j;
      logic        nxt, up;
      top = (cfg_stack_count == 0) ? 0 : cfg_stack_count - 1;
      c = corner_idx;
      i = slice_idx;
      j = level_idx;
      v = '0;
      if (restart) begin
         walk_phase    = cmvg_pkg::PH_BASE;
         slice_idx     = 0;
         level_idx     = 0;
         corner_idx    = 0;
         mesh_finished = (cfg_slice_count == 0);
         c = 0;
         i = 0;
         j = 0;
      end
      if (mesh_finished || walk_phase == cmvg_pkg::PH_BAD) begin
         v.done = 1'b1;
         return v;
      end
      case (walk_phase)
         cmvg_pkg::PH_BASE: begin
            if (c == 0) v = ring_vertex(i, 1'b0, 0);
            else if (c == 2) v = ring_vertex(i, 1'b1, 0);
            c++;
            if (c >= 3) begin
               c = 0;
               j = 0;
               i++;
               if (i >= cfg_slice_count) begin
                  i = 0;
                  walk_phase = (top > 0) ? cmvg_pkg::PH_SIDE : cmvg_pkg::PH_APEX;
               end
            end
         end
         cmvg_pkg::PH_SIDE: begin
            nxt = (c == 1 || c == 4 || c == 5);
            up  = (c == 2 || c == 3 || c == 5);
            v   = ring_vertex(i, nxt, up ? j + 1 : j);
            c++;
            if (c >= 6) begin
               c = 0;
               j++;
               if (j >= top) begin
                  j = 0;
                  walk_phase = cmvg_pkg::PH_APEX;
               end
            end
         end
         default: begin
            if (c < 2) begin
               v = ring_vertex(i, c == 1, top);
            end else begin
               v.y = cfg_cone_height;
               if (i + 1 >= cfg_slice_count) v.last = 1'b1;
            end
            c++;
            if (c >= 3) begin
               c = 0;
               j = 0;
               i++;
               if (i >= cfg_slice_count) mesh_finished = 1'b1;
               else walk_phase = (top > 0) ? cmvg_pkg::PH_SIDE : cmvg_pkg::PH_APEX;
            end
         end
      endcase
      corner_idx = c & 7;
      slice_idx  = i & 10'h3FF;
      level_idx  = j & 10'h3FF;
      return v;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_restart_q.size() != 0) begin
            req_valid   <= 1'b1;
            req_restart <= pending_restart_q.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure; a pattern never stalls for a full window
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_cycle == 0) begin
            if ($urandom_range(0, 3) == 0) stall_pattern = 16'hFFFF;
            else stall_pattern = 16'($urandom()) | 16'h0001;
         end
         rsp_ready <= stall_pattern[stall_cycle[3:0]];
         stall_cycle++;
      end
   end

   // monitor: register writes, predictions and response checks
   always @(posedge clock) begin : monitor
      vertex_type want;
      if (reset) begin
         cfg_base_radius      = 15'd256;
         cfg_cone_height      = 15'd256;
         cfg_slice_count      = 10'd8;
         cfg_stack_count      = 10'd4;
         cfg_angle_step       = 16'd8192;
         cfg_ring_radius_step = 15'd64;
         cfg_ring_height_step = 15'd64;
         walk_phase    = cmvg_pkg::PH_BASE;
         slice_idx     = 0;
         level_idx     = 0;
         corner_idx    = 0;
         mesh_finished = 1'b1;
         req_taken     = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (csr_wr_en) begin
            case (csr_index)
               cmvg_pkg::CSR_BASE_RADIUS:      cfg_base_radius      = csr_wdata[14:0];
               cmvg_pkg::CSR_CONE_HEIGHT:      cfg_cone_height      = csr_wdata[14:0];
               cmvg_pkg::CSR_SLICE_COUNT:      cfg_slice_count      = csr_wdata[9:0];
               cmvg_pkg::CSR_STACK_COUNT:      cfg_stack_count      = csr_wdata[9:0];
               cmvg_pkg::CSR_ANGLE_STEP:       cfg_angle_step       = csr_wdata;
               cmvg_pkg::CSR_RING_RADIUS_STEP: cfg_ring_radius_step = csr_wdata[14:0];
               cmvg_pkg::CSR_RING_HEIGHT_STEP: cfg_ring_height_step = csr_wdata[14:0];
               default: ;
            endcase
         end
         // oldest expectation first, then the request taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (vertex_expect_q.size() == 0) begin
               $error("response transaction with no vertex expected");
               error_count++;
            end else begin
               want = vertex_expect_q.pop_front();
               vertices_seen++;
               if (want.last) meshes_closed++;
               if (rsp_vert_x !== want.x) begin
                  $error("vert_x mismatch: expected %0d, got %0d", want.x, rsp_vert_x);
                  error_count++;
               end
               if (rsp_vert_y !== want.y) begin
                  $error("vert_y mismatch: expected %0d, got %0d", want.y, rsp_vert_y);
                  error_count++;
               end
               if (rsp_vert_z !== want.z) begin
                  $error("vert_z mismatch: expected %0d, got %0d", want.z, rsp_vert_z);
                  error_count++;
               end
               if (rsp_last_vertex !== want.last) begin
                  $error("last_vertex mismatch: expected %0d, got %0d", want.last,
                         rsp_last_vertex);
                  error_count++;
               end
               if (rsp_mesh_done !== want.done) begin
                  $error("mesh_done mismatch: expected %0d, got %0d", want.done,
                         rsp_mesh_done);
                  error_count++;
               end
            end
         end
         if (req_taken) vertex_expect_q.push_back(next_vertex(req_restart));
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      while (pending_restart_q.size() != 0 || req_valid || vertex_expect_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input cmvg_pkg::csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic load_setup(input logic [15:0] radius, input logic [15:0] height,
                             input logic [15:0] slices, input logic [15:0] stacks,
                             input logic [15:0] astep, input logic [15:0] rstep,
                             input logic [15:0] hstep);
      wait_idle();
      write_reg(cmvg_pkg::CSR_BASE_RADIUS, radius);
      write_reg(cmvg_pkg::CSR_CONE_HEIGHT, height);
      write_reg(cmvg_pkg::CSR_SLICE_COUNT, slices);
      write_reg(cmvg_pkg::CSR_STACK_COUNT, stacks);
      write_reg(cmvg_pkg::CSR_ANGLE_STEP, astep);
      write_reg(cmvg_pkg::CSR_RING_RADIUS_STEP, rstep);
      write_reg(cmvg_pkg::CSR_RING_HEIGHT_STEP, hstep);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      setups_loaded++;
   endtask

   // first transaction carries first_restart; noisy ones sprinkle stray restarts
   task automatic push_items(input bit first_restart, input int count, input bit noisy);
      for (int n = 0; n < count; n++) begin
         if (n == 0) pending_restart_q.push_back(first_restart);
         else pending_restart_q.push_back(noisy && ($urandom_range(0, 99) == 0));
      end
      items_queued += count;
   endtask

   function automatic logic [15:0] pick_word(input int unsigned maxval,
                                             input int unsigned typical);
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'(maxval);
         2, 3:    return 16'(typical);
         default: return 16'($urandom_range(0, maxval));
      endcase
   endfunction

   initial begin : stimulus
      logic [63:0] pos, f, x, x2, t, s, v, d;
      logic [1:0]  quad;
      logic [15:0] sc, st, br, ch, as, rrs, rhs;
      int unsigned top, full, pick, count;

      // Q1.15 sine table from a truncating degree-11 Taylor series
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         pos  = ({32'd0, 32'(k)} << 32) / TABLE_DEPTH;
         quad = pos[31:30];
         f    = pos & (UNIT_Q30 - 1);
         if (quad[0]) f = UNIT_Q30 - f;
         x  = (f * HALF_PI_FIX) >> 30;
         x2 = (x * x) >> 30;
         t  = UNIT_Q30;
         for (int n = 0; n < 5; n++) begin
            case (n)
               0:       d = 64'd110;
               1:       d = 64'd72;
               2:       d = 64'd42;
               3:       d = 64'd20;
               default: d = 64'd6;
            endcase
            t = UNIT_Q30 - ((x2 * t) >> 30) / d;
         end
         s = (x * t) >> 30;
         v = (s + 64'd16384) >> 15;
         if (v > 64'd32767) v = 64'd32767;
         if (quad[1]) v = (64'h10000 - v) & 64'hFFFF;
         sine_tbl[k] = v[15:0];
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: idle until restart, then the start of the default mesh
      push_items(1'b0, 2, 1'b0);
      push_items(1'b1, 4, 1'b0);
      // zero slices: restart leaves the mesh empty
      load_setup(16'd256, 16'd256, 16'd0, 16'd4, 16'd8192, 16'd64, 16'd64);
      push_items(1'b1, 2, 1'b0);
      // one slice, one stack, extreme radius, height and angle
      load_setup(16'd32767, 16'd32767, 16'd1, 16'd1, 16'd65535, 16'd0, 16'd32767);
      push_items(1'b1, 7, 1'b0);
      // zero stack count behaves as a single stack; zero radius and height
      load_setup(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd32767, 16'd32767);
      push_items(1'b1, 6, 1'b0);

      while (items_queued < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)       sc = 16'd0;
         else if (pick < 7)  sc = 16'd1023;
         else if (pick < 10) sc = 16'($urandom_range(6, 1022));
         else                sc = 16'($urandom_range(1, 5));
         pick = $urandom_range(0, 99);
         if (pick < 4)       st = 16'd0;
         else if (pick < 7)  st = 16'd1023;
         else if (pick < 10) st = 16'($urandom_range(5, 1022));
         else                st = 16'($urandom_range(1, 4));
         br  = pick_word(32767, 256);
         ch  = pick_word(32767, 256);
         as  = pick_word(65535, (sc == 0) ? 8192 : 65536 / sc);
         rrs = pick_word(32767, br / ((st == 0) ? 1 : st));
         rhs = pick_word(32767, ch / ((st == 0) ? 1 : st));
         load_setup(br, ch, sc, st, as, rrs, rhs);

         top  = (st == 0) ? 0 : st - 1;
         full = sc * (6 + 6 * top);
         if ($urandom_range(0, 3) == 0) begin
            // keep walking whatever mesh is in progress under the new registers
            push_items(1'b0, $urandom_range(3, 30), 1'b1);
         end else begin
            if (full == 0) count = $urandom_range(1, 3);
            else if (full > 160 || $urandom_range(0, 3) == 0)
               count = $urandom_range(1, (full > 60) ? 60 : full);
            else count = full + $urandom_range(0, 2);
            push_items(1'b1, count, 1'b1);
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      $display("Run covered %0d vertex transactions over %0d register settings,", vertices_seen,
               setups_loaded);
      $display("with %0d meshes walked through to their last vertex.", meshes_closed);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[cone_mesh_vertex_generator.f]
+incdir+rtl
rtl/cmvg_pkg.sv
rtl/cmvg_sine_rom.sv
rtl/cone_mesh_vertex_generator.sv
bench/tb.sv
